@@ design/obrb_pkg.sv @@
// Shared types and constants for the overwriting byte ring buffer.
`default_nettype none

package obrb_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 7;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [BYTE_W-1:0] write_byte;
    logic [LEN_W-1:0]  fetch_length;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] read_byte;
    logic              byte_present;
    logic              last_of_fetch;
  } out_t;

  // One slot issued by the fetch sequencer towards the output stage.
  typedef struct packed {
    logic valid;
    logic present;
    logic last;
  } issue_t;

endpackage

`default_nettype wire

@@ design/obrb_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module obrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/obrb_ctrl.sv @@
// Index registers, request decode and fetch sequencer driving the byte store.
`default_nettype none

module obrb_ctrl #(
  parameter int DEPTH = 4096,
  parameter int MAX_FETCH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire obrb_pkg::in_t             in_data,
  input  wire logic                      room,
  output obrb_pkg::issue_t               issue,
  output logic                           we,
  output logic [AW-1:0]                  waddr,
  output logic [obrb_pkg::BYTE_W-1:0]    wdata,
  output logic                           re,
  output logic [AW-1:0]                  raddr
);

  localparam int CW = (AW + 1 > obrb_pkg::LEN_W) ? AW + 1 : obrb_pkg::LEN_W;

  logic                       busy;
  logic                       empty_req;
  logic [obrb_pkg::LEN_W-1:0] remaining;
  logic [AW-1:0]              write_index;
  logic [AW-1:0]              read_index;

  logic                       accept;
  logic                       issue_go;
  logic [obrb_pkg::LEN_W-1:0] flen_sat;
  logic [AW:0]                avail;
  logic [CW-1:0]              avail_c;
  logic [CW-1:0]              flen_c;
  logic [obrb_pkg::LEN_W-1:0] count;

  function automatic logic [AW-1:0] inc_index(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  // No request is taken while reset is held.
  assign in_stall = busy || rst;
  assign accept   = in_valid && !in_stall;

  // Bytes held between the indices, modulo DEPTH, and the fetch count they and MAX_FETCH allow.
  always_comb begin
    flen_sat = (in_data.fetch_length > obrb_pkg::LEN_W'(MAX_FETCH)) ?
               obrb_pkg::LEN_W'(MAX_FETCH) : in_data.fetch_length;
    if (write_index >= read_index) begin
      avail = {1'b0, write_index} - {1'b0, read_index};
    end else begin
      avail = {1'b0, write_index} + (AW + 1)'(DEPTH) - {1'b0, read_index};
    end
    avail_c = CW'(avail);
    flen_c  = CW'(flen_sat);
    count   = (avail_c < flen_c) ? obrb_pkg::LEN_W'(avail_c) : flen_sat;
  end

  assign issue_go      = busy && room;
  assign issue.valid   = issue_go;
  assign issue.present = !empty_req;
  assign issue.last    = empty_req || (remaining == obrb_pkg::LEN_W'(1));

  assign we    = accept && (in_data.kind == obrb_pkg::KIND_WRITE);
  assign waddr = write_index;
  assign wdata = in_data.write_byte;
  assign re    = issue_go && !empty_req;
  assign raddr = read_index;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      empty_req   <= 1'b0;
      remaining   <= '0;
      write_index <= '0;
      read_index  <= '0;
    end else begin
      if (accept) begin
        if (in_data.kind == obrb_pkg::KIND_WRITE) begin
          write_index <= inc_index(write_index);
        end else begin
          busy      <= 1'b1;
          empty_req <= (count == '0);
          remaining <= count;
        end
      end
      if (issue_go) begin
        if (!empty_req) begin
          read_index <= inc_index(read_index);
          remaining  <= remaining - 1'b1;
        end
        if (issue.last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ design/obrb_out.sv @@
// Output register with a skid entry, fed in the cycle after each store read.
`default_nettype none

module obrb_out (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire obrb_pkg::issue_t            issue,
  input  wire logic [obrb_pkg::BYTE_W-1:0] rdata,
  output logic                             room,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output obrb_pkg::out_t                   out_data
);

  logic           pend;
  logic           pend_present;
  logic           pend_last;
  logic           skid_valid;
  obrb_pkg::out_t skid;

  logic           out_valid_next;
  obrb_pkg::out_t out_data_next;
  logic           skid_valid_next;
  obrb_pkg::out_t skid_next;
  obrb_pkg::out_t pend_word;
  logic           leave;
  logic           take;
  logic [1:0]     occ;

  always_comb begin
    pend_word.read_byte     = pend_present ? rdata : '0;
    pend_word.byte_present  = pend_present;
    pend_word.last_of_fetch = pend_last;
  end

  assign leave = out_valid && !out_stall;
  assign take  = !out_valid || !out_stall;

  // A new slot may be issued only if its data is sure of a place next cycle.
  assign occ  = 2'(pend) + 2'(out_valid) + 2'(skid_valid) - 2'(leave);
  assign room = occ < 2'd2;

  always_comb begin
    out_valid_next  = out_valid;
    out_data_next   = out_data;
    skid_valid_next = skid_valid;
    skid_next       = skid;
    if (take) begin
      if (skid_valid) begin
        out_valid_next  = 1'b1;
        out_data_next   = skid;
        skid_valid_next = pend;
        skid_next       = pend_word;
      end else begin
        out_valid_next  = pend;
        out_data_next   = pend_word;
        skid_valid_next = 1'b0;
      end
    end else if (pend) begin
      skid_valid_next = 1'b1;
      skid_next       = pend_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend       <= 1'b0;
      skid_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      pend       <= issue.valid;
      skid_valid <= skid_valid_next;
      out_valid  <= out_valid_next;
    end
    pend_present <= issue.present;
    pend_last    <= issue.last;
    skid         <= skid_next;
    out_data     <= out_data_next;
  end

endmodule

`default_nettype wire

@@ design/overwriting_byte_ring_buffer.sv @@
// Top level of the overwriting byte ring buffer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------------
//   in      | input     | in_valid/in_stall  | kind, write_byte, fetch_length
//   out     | output    | out_valid/out_stall| read_byte, byte_present, last_of_fetch
//
// A write request does not stall the input; another request is accepted in the next cycle.
// A fetch request of N bytes (one result when nothing is returned) issues one store
// read per cycle while the output has room, stalling input until its last slot issues;
// results flow out one per cycle while out_stall is low, paced by the single read port.
// Reset clears both indices and the output stage; the store itself is not cleared.
// A stalled output backs up through a one-entry skid and pauses the store reads.
`default_nettype none

module overwriting_byte_ring_buffer #(
  parameter int DEPTH = 4096,
  parameter int MAX_FETCH = 64
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire obrb_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output obrb_pkg::out_t      out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                          room;
  obrb_pkg::issue_t              issue;
  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [obrb_pkg::BYTE_W-1:0]   wdata;
  logic                          re;
  logic [AW-1:0]                 raddr;
  logic [obrb_pkg::BYTE_W-1:0]   rdata;

  obrb_ctrl #(
    .DEPTH     (DEPTH),
    .MAX_FETCH (MAX_FETCH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .room     (room),
    .issue    (issue),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr)
  );

  obrb_ram #(
    .WIDTH (obrb_pkg::BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  obrb_out u_out (
    .clk       (clk),
    .rst       (rst),
    .issue     (issue),
    .rdata     (rdata),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ dv/overwriting_byte_ring_buffer_tb.sv @@
// Self-checking testbench for the overwriting byte ring buffer.
module overwriting_byte_ring_buffer_tb;

  localparam int DEPTH       = 4096;
  localparam int MAX_FETCH   = 64;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 200000;

  logic           clk = 1'b0;
  logic           rst = 1'b1;
  logic           in_valid = 1'b0;
  logic           in_stall;
  obrb_pkg::in_t  in_data = '0;
  logic           out_valid;
  logic           out_stall = 1'b0;
  obrb_pkg::out_t out_data;

  overwriting_byte_ring_buffer #(
    .DEPTH(DEPTH),
    .MAX_FETCH(MAX_FETCH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  always #2 clk = ~clk;

  // Shadow copy of the ring, kept by the driver as requests are accepted.
  logic [7:0]       ring_mem [DEPTH];
  logic [IDX_W-1:0] wr_ptr = '0;
  logic [IDX_W-1:0] rd_ptr = '0;

  obrb_pkg::in_t  requests_to_send [$];
  obrb_pkg::out_t bytes_due [$];
  obrb_pkg::out_t due;

  int send_idle_pct = 8;
  int recv_idle_pct = 64;
  int hold_asks = 0;
  int hold_taken = 0;
  int hold_left = 0;
  int cycles = 0;
  int mismatches = 0;
  int writes_done = 0;
  int fetches_done = 0;
  int results_seen = 0;

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH cycle %0d: %s", cycles, msg);
  endtask

  // Applies one accepted request to the shadow ring and queues the bytes it returns.
  task automatic ring_apply(input obrb_pkg::in_t req);
    logic [IDX_W-1:0] avail;
    int unsigned want;
    int unsigned count;
    obrb_pkg::out_t res;
    if (req.kind == obrb_pkg::KIND_WRITE) begin
      writes_done++;
      ring_mem[wr_ptr] = req.write_byte;
      wr_ptr = wr_ptr + 1'b1;
    end else begin
      fetches_done++;
      want = (req.fetch_length > MAX_FETCH) ? MAX_FETCH : req.fetch_length;
      avail = wr_ptr - rd_ptr;
      count = (avail < want) ? avail : want;
      if (count == 0) begin
        res.read_byte = '0;
        res.byte_present = 1'b0;
        res.last_of_fetch = 1'b1;
        bytes_due.push_back(res);
      end else begin
        for (int k = 0; k < count; k++) begin
          res.read_byte = ring_mem[rd_ptr];
          res.byte_present = 1'b1;
          res.last_of_fetch = (k + 1 == count);
          bytes_due.push_back(res);
          rd_ptr = rd_ptr + 1'b1;
        end
      end
    end
  endtask

  task automatic push_write(input logic [7:0] b);
    obrb_pkg::in_t req;
    req.kind = obrb_pkg::KIND_WRITE;
    req.write_byte = b;
    req.fetch_length = obrb_pkg::LEN_W'($urandom_range(0, 127));
    requests_to_send.push_back(req);
  endtask

  task automatic push_fetch(input logic [obrb_pkg::LEN_W-1:0] len);
    obrb_pkg::in_t req;
    req.kind = obrb_pkg::KIND_FETCH;
    req.write_byte = 8'($urandom_range(0, 255));
    req.fetch_length = len;
    requests_to_send.push_back(req);
  endtask

  // Mostly writes, with fetches biased towards short lengths so data builds up.
  task automatic queue_random(input int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 55) begin
        push_write(8'($urandom_range(0, 255)));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 80) push_fetch(obrb_pkg::LEN_W'($urandom_range(0, 16)));
        else if (pick < 95) push_fetch(obrb_pkg::LEN_W'($urandom_range(17, 64)));
        else push_fetch(obrb_pkg::LEN_W'($urandom_range(65, 127)));
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (requests_to_send.size() != 0 || in_valid || bytes_due.size() != 0);
    // Writes return nothing, so let the block settle before going on.
    repeat (SETTLE) @(negedge clk);
  endtask

  // Driver: offers the next request once the previous one has been taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_stall === 1'b0) begin
        ring_apply(in_data);
      end
      if (!in_valid || in_stall === 1'b0) begin
        if (requests_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_data <= requests_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall, including the long hold-off asked for by the stimulus.
  always @(posedge clk) begin
    if (hold_asks != hold_taken) begin
      hold_taken <= hold_asks;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Monitor: every result taken is checked against the oldest byte due.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_seen++;
      if (bytes_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result byte=%h present=%b last=%b",
                                out_data.read_byte, out_data.byte_present,
                                out_data.last_of_fetch));
      end else begin
        due = bytes_due.pop_front();
        if (out_data.read_byte !== due.read_byte)
          flag_mismatch($sformatf("read_byte %h, expected %h",
                                  out_data.read_byte, due.read_byte));
        if (out_data.byte_present !== due.byte_present)
          flag_mismatch($sformatf("byte_present %b, expected %b",
                                  out_data.byte_present, due.byte_present));
        if (out_data.last_of_fetch !== due.last_of_fetch)
          flag_mismatch($sformatf("last_of_fetch %b, expected %b",
                                  out_data.last_of_fetch, due.last_of_fetch));
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("overwriting_byte_ring_buffer verification failed");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Empty fetches, a zero-length request, a short fetch and a saturated one.
    push_fetch(7'd64);
    push_fetch(7'd0);
    push_write(8'h00);
    push_write(8'hFF);
    push_write(8'hA5);
    push_write(8'h5A);
    push_fetch(7'd0);
    push_fetch(7'd1);
    push_fetch(7'd127);
    push_fetch(7'd1);
    push_write(8'h81);
    push_write(8'h7E);
    push_fetch(7'd65);
    push_write(8'h3C);
    push_fetch(7'd2);
    wait_drained();
    queue_random(20);
    wait_drained();

    send_idle_pct = 64;
    recv_idle_pct = 8;
    queue_random(20);
    wait_drained();

    // Receiver holds off while long fetches pile up behind it.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_asks++;
    for (int n = 0; n < 30; n++) push_write(8'($urandom_range(0, 255)));
    push_fetch(7'd127);
    push_fetch(7'd100);
    for (int n = 0; n < 8; n++) push_write(8'($urandom_range(0, 255)));
    push_fetch(7'd20);
    wait_drained();
    queue_random(15);
    wait_drained();

    if (bytes_due.size() != 0)
      flag_mismatch($sformatf("%0d expected results never arrived", bytes_due.size()));
    $display("Ran %0d write and %0d fetch requests, checked %0d results.",
             writes_done, fetches_done, results_seen);
    $display("Covered empty and zero-length fetches, saturated lengths and a long stall.");
    if (mismatches == 0) begin
      $display("overwriting_byte_ring_buffer verification clean");
    end else begin
      $display("overwriting_byte_ring_buffer verification failed");
    end
    $finish;
  end

endmodule
